FILE: rtl/core/ffah_pkg.sv
`default_nettype none
package ffah_pkg;

	localparam int unsigned ADDR_W   = 48;
	localparam int unsigned ALIGN_W  = 21;
	localparam int unsigned BALIGN_W = 13;
	// wide enough for address + size + header + alignment slack
	localparam int unsigned WIDE_W   = 51;
	localparam logic [WIDE_W-1:0] HEADER_BYTES = WIDE_W'(32);

	localparam logic [2:0] CMD_ALLOC   = 3'd0;
	localparam logic [2:0] CMD_RESIZE  = 3'd1;
	localparam logic [2:0] CMD_FREE    = 3'd2;
	localparam logic [2:0] CMD_GETSIZE = 3'd3;
	localparam logic [2:0] CMD_ONHEAP  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
	localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;
	localparam logic [1:0] REG_BASE_ALIGN = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] size;
	} ffah_entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CHK,
		S_FOUND,
		S_ROOM,
		S_AL_INIT,
		S_AL_A,
		S_AL_B,
		S_UP_RD,
		S_UP_WR,
		S_RM_RD,
		S_RM_WR,
		S_DONE
	} ffah_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/first_fit_aligned_heap_allocator.sv
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_stall  | cmd, block_addr, req_size, req_align
// output   | out_valid / out_stall| status, result_addr, result_size, move_from, on_heap
// config   | cfg_we               | cfg_index, cfg_data
//
// One item at a time. Each item makes search passes over the table entries
// (lookup, gap scan) and, when the table is shifted, moves entries one at a
// time; a relocating resize does the most passes and moves.
// The single-read, single-write block table paces every pass.
// Reset clears the entry count and sets config to defaults; table contents need no clearing.
// in_stall is high while an item is in work or its result waits on out_stall.
module first_fit_aligned_heap_allocator
	import ffah_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           cmd,
	input  wire logic [ADDR_W-1:0]    block_addr,
	input  wire logic [ADDR_W-1:0]    req_size,
	input  wire logic [ALIGN_W-1:0]   req_align,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [ADDR_W-1:0]         result_addr,
	output logic [ADDR_W-1:0]         result_size,
	output logic [ADDR_W-1:0]         move_from,
	output logic                      on_heap
);

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

	// config registers
	logic [ADDR_W-1:0]   heap_base_q, heap_limit_q;
	logic [BALIGN_W-1:0] base_align_q;

	// block table: one read port with registered data, one write port
	ffah_entry_t mem_q [MAX_BLOCKS];
	ffah_entry_t rdata_q;
	logic [IDX_W-1:0] rd_idx;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	ffah_entry_t      mem_wd;

	ffah_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, ins_q, ins_d;
	logic [2:0]          cmd_q, cmd_d;
	logic [ADDR_W-1:0]   p_q, p_d, size_q, size_d, ksize_q, ksize_d;
	logic [WIDE_W-1:0]   sizeh_q, sizeh_d, prev_end_q, prev_end_d, cand_q, cand_d;
	logic [ALIGN_W-1:0]  mask_q, mask_d;
	logic                reloc_q, reloc_d, found_q, found_d;
	logic                out_valid_q, out_valid_d;
	logic [1:0]          status_q, status_d;
	logic [ADDR_W-1:0]   raddr_q, raddr_d, rsize_q, rsize_d, from_q, from_d;
	logic                onh_q, onh_d;

	logic                in_acc;
	logic [ALIGN_W-1:0]  align_max, align_one;
	logic [WIDE_W-1:0]   cand_calc, next_hdr, kp1;
	logic                fit;

	assign in_stall    = (state_q != S_IDLE) || out_valid_q;
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_addr = raddr_q;
	assign result_size = rsize_q;
	assign move_from   = from_q;
	assign on_heap     = onh_q;

	// effective alignment: larger of request and default, cut to its top bit
	always_comb begin
		align_max = (req_align > ALIGN_W'(base_align_q)) ? req_align
			: ALIGN_W'(base_align_q);
		align_one = ALIGN_W'(1);
		for (int b = 0; b < ALIGN_W; b++) begin
			if (align_max[b]) align_one = ALIGN_W'(1) << b;
		end
	end

	// gap candidate: first aligned address past previous end plus a header
	assign cand_calc = (prev_end_q + HEADER_BYTES + WIDE_W'(mask_q))
		& ~WIDE_W'(mask_q);

	// next header limit for the gap under test: table entry or heap end
	assign next_hdr = (idx_q < count_q) ? WIDE_W'(rdata_q.addr) : WIDE_W'(heap_limit_q);
	assign fit = (next_hdr >= HEADER_BYTES) && (cand_q + sizeh_q <= next_hdr);
	assign kp1 = WIDE_W'(idx_q) + WIDE_W'(1);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		ins_d       = ins_q;
		cmd_d       = cmd_q;
		p_d         = p_q;
		size_d      = size_q;
		ksize_d     = ksize_q;
		sizeh_d     = sizeh_q;
		prev_end_d  = prev_end_q;
		cand_d      = cand_q;
		mask_d      = mask_q;
		reloc_d     = reloc_q;
		found_d     = found_q;
		out_valid_d = out_valid_q && out_stall;
		status_d    = status_q;
		raddr_d     = raddr_q;
		rsize_d     = rsize_q;
		from_d      = from_q;
		onh_d       = onh_q;
		rd_idx      = idx_q[IDX_W-1:0];
		mem_we      = 1'b0;
		mem_wa      = idx_q[IDX_W-1:0];
		mem_wd      = rdata_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd_d    = cmd;
					p_d      = block_addr;
					size_d   = req_size;
					sizeh_d  = WIDE_W'(req_size) + HEADER_BYTES;
					mask_d   = align_one - ALIGN_W'(1);
					reloc_d  = 1'b0;
					idx_d    = '0;
					status_d = ST_OK;
					raddr_d  = '0;
					rsize_d  = '0;
					from_d   = '0;
					onh_d    = 1'b0;
					priority if (cmd == CMD_ALLOC) begin
						state_d = S_AL_INIT;
					end else if (cmd == CMD_RESIZE) begin
						state_d = (block_addr == '0) ? S_AL_INIT : S_FIND_RD;
					end else if (cmd == CMD_FREE || cmd == CMD_GETSIZE) begin
						state_d = S_FIND_RD;
					end else if (cmd == CMD_ONHEAP) begin
						onh_d = (WIDE_W'(block_addr) >= WIDE_W'(heap_base_q)
							+ (HEADER_BYTES << 1)) && (block_addr < heap_limit_q);
						state_d = S_DONE;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			// linear lookup of p
			S_FIND_RD: begin
				if (idx_q == count_q) begin
					found_d = 1'b0;
					state_d = S_FOUND;
				end else begin
					state_d = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if (rdata_q.addr == p_q) begin
					found_d = 1'b1;
					ksize_d = rdata_q.size;
					state_d = S_FOUND;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = S_FIND_RD;
				end
			end
			S_FOUND: begin
				priority if (reloc_q) begin
					// old copy after a successful move: drop it
					state_d = found_q ? S_RM_RD : S_DONE;
				end else if (!found_q) begin
					status_d = ST_NOTFOUND;
					state_d  = S_DONE;
				end else if (cmd_q == CMD_GETSIZE) begin
					rsize_d = ksize_q;
					state_d = S_DONE;
				end else if (cmd_q == CMD_FREE || size_q == '0) begin
					state_d = S_RM_RD;
				end else begin
					// read the following entry to learn the room above
					rd_idx  = kp1[IDX_W-1:0];
					state_d = S_ROOM;
				end
			end
			S_ROOM: begin
				if ((size_q > ksize_q) && (((p_q[ALIGN_W-1:0] & mask_q) != '0)
					|| !((((kp1 < WIDE_W'(count_q)) ? WIDE_W'(rdata_q.addr)
					: WIDE_W'(heap_limit_q)) >= HEADER_BYTES)
					&& (WIDE_W'(p_q) + sizeh_q <= ((kp1 < WIDE_W'(count_q))
					? WIDE_W'(rdata_q.addr) : WIDE_W'(heap_limit_q)))))) begin
					reloc_d = 1'b1;
					state_d = S_AL_INIT;
				end else begin
					mem_we      = 1'b1;
					mem_wd.addr = p_q;
					mem_wd.size = size_q;
					raddr_d     = p_q;
					state_d     = S_DONE;
				end
			end
			S_AL_INIT: begin
				priority if (size_q == '0) begin
					state_d = S_DONE;
				end else if (count_q == CNT_MAX) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					idx_d      = '0;
					prev_end_d = WIDE_W'(heap_base_q) + HEADER_BYTES;
					state_d    = S_AL_A;
				end
			end
			// gap scan: align candidate while the next entry is read
			S_AL_A: begin
				cand_d  = cand_calc;
				state_d = S_AL_B;
			end
			S_AL_B: begin
				priority if (fit) begin
					ins_d   = idx_q;
					idx_d   = count_q;
					state_d = S_UP_RD;
				end else if (idx_q == count_q) begin
					status_d = ST_NO_FIT;
					state_d  = S_DONE;
				end else begin
					prev_end_d = WIDE_W'(rdata_q.addr) + WIDE_W'(rdata_q.size);
					idx_d      = idx_q + CNT_W'(1);
					state_d    = S_AL_A;
				end
			end
			// open a slot at ins_q by moving entries up, top first
			S_UP_RD: begin
				if (idx_q == ins_q) begin
					mem_we      = 1'b1;
					mem_wd.addr = cand_q[ADDR_W-1:0];
					mem_wd.size = size_q;
					count_d     = count_q + CNT_W'(1);
					raddr_d     = cand_q[ADDR_W-1:0];
					if (reloc_q) begin
						from_d  = p_q;
						idx_d   = '0;
						state_d = S_FIND_RD;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					rd_idx  = IDX_W'(idx_q - CNT_W'(1));
					state_d = S_UP_WR;
				end
			end
			S_UP_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_q - CNT_W'(1);
				state_d = S_UP_RD;
			end
			// close the slot at idx_q by moving entries down
			S_RM_RD: begin
				if (WIDE_W'(idx_q) + WIDE_W'(1) >= WIDE_W'(count_q)) begin
					count_d = count_q - CNT_W'(1);
					state_d = S_DONE;
				end else begin
					rd_idx  = kp1[IDX_W-1:0];
					state_d = S_RM_WR;
				end
			end
			S_RM_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_q + CNT_W'(1);
				state_d = S_RM_RD;
			end
			S_DONE: begin
				out_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rdata_q <= mem_q[rd_idx];
	end

	// payload registers
	always_ff @(posedge clk) begin
		ins_q      <= ins_d;
		cmd_q      <= cmd_d;
		p_q        <= p_d;
		size_q     <= size_d;
		ksize_q    <= ksize_d;
		sizeh_q    <= sizeh_d;
		prev_end_q <= prev_end_d;
		cand_q     <= cand_d;
		mask_q     <= mask_d;
		found_q    <= found_d;
		status_q   <= status_d;
		raddr_q    <= raddr_d;
		rsize_q    <= rsize_d;
		from_q     <= from_d;
		onh_q      <= onh_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			reloc_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			heap_base_q  <= '0;
			heap_limit_q <= ADDR_W'(1048576);
			base_align_q <= BALIGN_W'(16);
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			reloc_q     <= reloc_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAP_BASE:  heap_base_q  <= cfg_data;
					REG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					REG_BASE_ALIGN: base_align_q <= cfg_data[BALIGN_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import ffah_pkg::*;

	localparam int TBL_DEPTH = 64;
	localparam logic [63:0] HDR = 64'd32;

	typedef struct {
		logic [2:0]  op;
		logic [47:0] addr;
		logic [47:0] size;
		logic [20:0] align;
	} heap_req_t;

	typedef struct {
		logic [1:0]  st;
		logic [47:0] addr;
		logic [47:0] size;
		logic [47:0] from;
		logic        onh;
	} heap_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_HEAP_BASE;
	logic [47:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = CMD_ALLOC;
	logic [47:0] block_addr = '0;
	logic [47:0] req_size = '0;
	logic [20:0] req_align = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [47:0] result_addr;
	logic [47:0] result_size;
	logic [47:0] move_from;
	logic on_heap;

	first_fit_aligned_heap_allocator #(.MAX_BLOCKS(TBL_DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .block_addr(block_addr), .req_size(req_size), .req_align(req_align),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_addr(result_addr), .result_size(result_size),
		.move_from(move_from), .on_heap(on_heap)
	);

	always #5 clk = ~clk;

	// Shadow of the block table and its registers
	logic [63:0] blk_addr[TBL_DEPTH];
	logic [63:0] blk_size[TBL_DEPTH];
	int unsigned blk_count = 0;
	logic [63:0] heap_lo = 64'd0;
	logic [63:0] heap_hi = 64'd1048576;
	logic [12:0] min_align = 13'd16;

	heap_req_t   send_queue[$];
	heap_reply_t awaited_replies[$];
	logic [47:0] known_blocks[$];
	heap_req_t   cur_req;
	int tx_wait = 0;
	int rx_wait = 0;
	int rx_hold = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int mismatches = 0;

	function automatic logic [63:0] effective_align(input logic [20:0] req);
		logic [63:0] a;
		a = (64'(req) > 64'(min_align)) ? 64'(req) : 64'(min_align);
		if (a == 0)
			return 64'd1;
		while ((a & (a - 1)) != 0)
			a &= a - 1;
		return a;
	endfunction

	function automatic logic [63:0] header_of(input logic [63:0] d);
		return (d >= HDR) ? d - HDR : 64'd0;
	endfunction

	function automatic int find_block(input logic [63:0] a);
		for (int i = 0; i < blk_count; i++)
			if (blk_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void drop_block(input int k);
		for (int i = k; i + 1 < blk_count; i++) begin
			blk_addr[i] = blk_addr[i + 1];
			blk_size[i] = blk_size[i + 1];
		end
		blk_count--;
	endfunction

	// First fit over the gaps in address order; insert the new block in place
	function automatic logic [1:0] first_fit(input logic [63:0] sz, input logic [63:0] al,
			output logic [63:0] got);
		logic [63:0] prev_end, nxt, cand;
		got = 0;
		if (sz == 0)
			return ST_OK;
		if (blk_count >= TBL_DEPTH)
			return ST_FULL;
		for (int i = 0; i <= blk_count; i++) begin
			prev_end = (i == 0) ? heap_lo + HDR : blk_addr[i - 1] + blk_size[i - 1];
			nxt = (i < blk_count) ? header_of(blk_addr[i]) : header_of(heap_hi);
			cand = (prev_end + HDR + al - 1) & ~(al - 1);
			if (cand + sz <= nxt) begin
				for (int j = blk_count; j > i; j--) begin
					blk_addr[j] = blk_addr[j - 1];
					blk_size[j] = blk_size[j - 1];
				end
				blk_addr[i] = cand;
				blk_size[i] = sz;
				blk_count++;
				got = cand;
				if (known_blocks.size() >= 64)
					void'(known_blocks.pop_front());
				known_blocks.push_back(cand[47:0]);
				return ST_OK;
			end
		end
		return ST_NO_FIT;
	endfunction

	function automatic heap_reply_t predict_heap_op(input heap_req_t r);
		heap_reply_t o;
		logic [63:0] p, sz, al, got, room;
		int k;
		o = '{default: '0};
		p = 64'(r.addr);
		sz = 64'(r.size);
		al = effective_align(r.align);
		case (r.op)
			CMD_ALLOC: begin
				o.st = first_fit(sz, al, got);
				o.addr = got[47:0];
			end
			CMD_RESIZE: begin
				if (p == 0) begin
					o.st = first_fit(sz, al, got);
					o.addr = got[47:0];
				end else begin
					k = find_block(p);
					if (k < 0)
						o.st = ST_NOTFOUND;
					else if (sz == 0)
						drop_block(k);
					else begin
						room = (k + 1 < blk_count) ? header_of(blk_addr[k + 1])
							: header_of(heap_hi);
						if (sz > blk_size[k] && ((p & (al - 1)) != 0 || p + sz > room)) begin
							o.st = first_fit(sz, al, got);
							if (o.st == ST_OK) begin
								k = find_block(p);
								if (k >= 0)
									drop_block(k);
								o.addr = got[47:0];
								o.from = p[47:0];
							end
						end else begin
							blk_size[k] = sz;
							o.addr = p[47:0];
						end
					end
				end
			end
			CMD_FREE: begin
				k = find_block(p);
				if (k < 0)
					o.st = ST_NOTFOUND;
				else
					drop_block(k);
			end
			CMD_GETSIZE: begin
				k = find_block(p);
				if (k < 0)
					o.st = ST_NOTFOUND;
				else
					o.size = blk_size[k][47:0];
			end
			CMD_ONHEAP: o.onh = (p >= heap_lo + 2 * HDR) && (p < heap_hi);
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Driver: present queued items, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (!in_valid || !in_stall) begin
				if (in_valid) begin
					awaited_replies.push_back(predict_heap_op(cur_req));
					tx_wait = no_idle ? 0 : $urandom_range(0, 11);
				end
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (send_queue.size() > 0) begin
					cur_req = send_queue.pop_front();
					cmd <= cur_req.op;
					block_addr <= cur_req.addr;
					req_size <= cur_req.size;
					req_align <= cur_req.align;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		heap_reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_replies.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					mismatches++;
				end else begin
					want = awaited_replies.pop_front();
					if (status !== want.st)
						report_mismatch("status", 48'(status), 48'(want.st));
					if (result_addr !== want.addr)
						report_mismatch("result_addr", result_addr, want.addr);
					if (result_size !== want.size)
						report_mismatch("result_size", result_size, want.size);
					if (move_from !== want.from)
						report_mismatch("move_from", move_from, want.from);
					if (on_heap !== want.onh)
						report_mismatch("on_heap", 48'(on_heap), 48'(want.onh));
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 11);
			end
			// take a hold request once, then count it down
			if (hold_req) begin
				rx_hold = 400;
				hold_req = 1'b0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom} >> 16);
	endfunction

	function automatic logic [47:0] pick_size();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return rand48();
			2: return 48'($urandom_range(200, 3000));
			default: return 48'($urandom_range(1, 160));
		endcase
	endfunction

	function automatic logic [20:0] pick_align();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 21'($urandom);
			2: return 21'h100000;
			default: return 21'(1) << $urandom_range(0, 8);
		endcase
	endfunction

	function automatic logic [47:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && known_blocks.size() > 0)
			return known_blocks[$urandom_range(0, known_blocks.size() - 1)];
		if (r < 80)
			return '0;
		if (r < 92)
			return heap_lo[47:0] + 48'($urandom_range(0, 12000));
		return rand48();
	endfunction

	task automatic queue_op(input logic [2:0] op, input logic [47:0] a, input logic [47:0] s,
			input logic [20:0] al);
		send_queue.push_back('{op: op, addr: a, size: s, align: al});
	endtask

	// Hold the sender until every predicted result has come back
	task automatic drain();
		while (send_queue.size() > 0 || in_valid || awaited_replies.size() > 0)
			@(posedge clk);
	endtask

	task automatic set_heap(input logic [47:0] lo, input logic [47:0] hi, input logic [12:0] al);
		drain();
		repeat (600) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_HEAP_BASE;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_HEAP_LIMIT;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= REG_BASE_ALIGN;
		cfg_data <= 48'(al);
		@(posedge clk);
		cfg_we <= 1'b0;
		heap_lo = 64'(lo);
		heap_hi = 64'(hi);
		min_align = al;
	endtask

	task automatic random_ops(input int n);
		int r;
		logic [2:0] op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35) op = CMD_ALLOC;
			else if (r < 60) op = CMD_RESIZE;
			else if (r < 78) op = CMD_FREE;
			else if (r < 88) op = CMD_GETSIZE;
			else if (r < 96) op = CMD_ONHEAP;
			else op = 3'($urandom_range(5, 7));
			queue_op(op, pick_addr(), pick_size(), pick_align());
			// refill the pool of live addresses every so often
			if (i % 16 == 15)
				drain();
		end
	endtask

	initial begin
		logic [47:0] lo;
		logic [47:0] a;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, base 0, limit 1 MiB, alignment 16
		queue_op(CMD_ALLOC, '0, '0, '0);
		queue_op(CMD_ALLOC, '0, 48'd16, '0);
		queue_op(CMD_ALLOC, '0, 48'd100, 21'd48);
		queue_op(CMD_ALLOC, '0, 48'd64, 21'h100000);
		queue_op(CMD_ALLOC, '0, '1, 21'h1fffff);
		queue_op(CMD_RESIZE, '0, 48'd40, 21'd256);
		queue_op(CMD_FREE, 48'h123457, '0, '0);
		queue_op(CMD_GETSIZE, '1, '0, '0);
		queue_op(CMD_RESIZE, 48'h999, 48'd8, '0);
		queue_op(CMD_ONHEAP, '0, '0, '0);
		queue_op(CMD_ONHEAP, 48'd64, '0, '0);
		queue_op(CMD_ONHEAP, 48'd1048575, '0, '0);
		queue_op(CMD_ONHEAP, 48'd1048576, '0, '0);
		queue_op(3'd5, '1, '1, '1);
		queue_op(3'd6, '0, '0, '0);
		queue_op(3'd7, 48'h5, 48'h5, 21'h5);
		drain();
		a = known_blocks[0];
		queue_op(CMD_GETSIZE, a, '0, '0);
		queue_op(CMD_RESIZE, a, 48'd8, '0);         // shrink in place
		queue_op(CMD_RESIZE, a, 48'd24, '0);        // grow in place
		queue_op(CMD_RESIZE, a, 48'd4000, 21'd4096); // grow, misaligned: relocate
		queue_op(CMD_RESIZE, known_blocks[1], '0, '0); // resize to zero frees
		queue_op(CMD_RESIZE, known_blocks[1], '0, '0); // now unknown
		queue_op(CMD_RESIZE, known_blocks[2], '1, '0); // cannot relocate, kept
		drain();
		random_ops(200);

		// compact heap without idling: fills the table
		no_idle = 1'b1;
		set_heap(48'h1000, 48'h3000, 13'd16);
		random_ops(200);
		no_idle = 1'b0;

		// long receiver hold while the sender keeps offering items
		set_heap(48'h4000, 48'h6800, 13'd1);
		@(negedge clk);
		hold_req = 1'b1;
		random_ops(30);
		random_ops(170);

		// extremes
		set_heap(48'hffff_ffff_c000, '1, 13'd4096);
		random_ops(150);
		set_heap('0, '0, 13'd4095);
		random_ops(100);
		set_heap('1, '1, 13'd1);
		random_ops(60);
		set_heap('0, 48'd20, 13'd16);
		random_ops(60);

		for (int ph = 0; ph < 6; ph++) begin
			lo = rand48() & 48'hffff_ffff_f000;
			if (lo > 48'hffff_ffff_0000)
				lo = 48'hffff_ffff_0000;
			set_heap(lo, lo + 48'($urandom_range(1500, 12000)),
				13'(1) << $urandom_range(0, 12));
			random_ops(210);
		end

		drain();
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/ffah_pkg.sv
rtl/core/first_fit_aligned_heap_allocator.sv
sim/testbench.sv
